/* rtl/cgdm_pkg.sv */
// Shared types and constants for the clipped grid distance map.
// Used by cgdm_core and clipped_grid_distance_map; depends on nothing.
package cgdm_pkg;

  // Default size limits handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_RADIUS = 66;

  // Field widths
  localparam int OP_W       = 2;
  localparam int VAL_W      = 8;
  localparam int COORD_W    = 8;
  localparam int DIST_W     = 20;
  localparam int FRAC_W     = 8;
  localparam int GRID_W     = 9;
  localparam int RAD_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // Channel payload widths, whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Largest integer distance sum that still fits once the fraction is appended
  localparam int CAND_LIMIT = (1 << (DIST_W - FRAC_W)) - 1;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Register reset values
  localparam logic [GRID_W-1:0] RST_GRID_WIDTH    = 9'd256;
  localparam logic [GRID_W-1:0] RST_GRID_HEIGHT   = 9'd256;
  localparam logic [DIST_W-1:0] RST_CLIP_SQ       = 20'd25600;
  localparam logic [RAD_W-1:0]  RST_WINDOW_RADIUS = 7'd12;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_COMPUTE = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH    = 2'd0,
    CFG_GRID_HEIGHT   = 2'd1,
    CFG_CLIP_SQ       = 2'd2,
    CFG_WINDOW_RADIUS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GRID_W-1:0] grid_width;
    logic [GRID_W-1:0] grid_height;
    logic [DIST_W-1:0] clip_sq;
    logic [RAD_W-1:0]  window_radius;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] cell_value;
    logic [COORD_W-1:0]      x_pos;
    logic [COORD_W-1:0]      y_pos;
    logic [DIST_W-1:0]       margin_sq;
  } req_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_sq;
    logic              out_of_range;
    logic              occupied;
    logic              clear_of_margin;
    logic              done_res;
  } res_t;

endpackage

/* rtl/clipped_grid_distance_map.sv */
// Top level of the clipped grid distance map: channels, registers, output stage.
// Depends on cgdm_pkg and cgdm_core (which uses cgdm_mul).
//
//   channel   direction  handshake           payload
//   in_       slave      in_tvalid/tready    tuser op, tdata cell/x/y/margin
//   out_      master     out_tvalid/tready   tdata distance and flags, tuser done
//   cfg_      slave      cfg_valid/ready     cfg_index, cfg_data
//
// A load passes index and address states, a query adds a read state, and an unused
// op goes straight to the result. Compute reads then updates every cell in two row
// passes, then reads, multiplies and accumulates per window row of each cell; the one
// shared multiplier and each map memory's single read port set this pace.
// Reset clears control only; the maps hold garbage until loaded and computed.
// The input is refused while a request is in progress; a result stalled at the
// output register does not hold back the next request.
module clipped_grid_distance_map #(
  parameter int MAX_WIDTH  = cgdm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cgdm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = cgdm_pkg::DEF_MAX_RADIUS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] cell_value, [15:8] x_pos, [23:16] y_pos, [43:24] margin_sq, rest zero
  input  logic [cgdm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] op
  input  logic [cgdm_pkg::OP_W-1:0]           in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [19:0] dist_sq, [20] out_of_range, [21] occupied, [22] clear_of_margin, [23] zero
  output logic [cgdm_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // done_res
  output logic                                out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cgdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cgdm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cgdm_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  req_t req;
  res_t core_res;
  res_t out_r, out_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic core_idle, core_res_valid, core_res_ready;

  // Registers are always writable; software writes them only while idle
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:    cfg_nxt.grid_width    = cfg_data[GRID_W-1:0];
        CFG_GRID_HEIGHT:   cfg_nxt.grid_height   = cfg_data[GRID_W-1:0];
        CFG_CLIP_SQ:       cfg_nxt.clip_sq       = cfg_data[DIST_W-1:0];
        CFG_WINDOW_RADIUS: cfg_nxt.window_radius = cfg_data[RAD_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  // Unpack the request
  assign req.op         = in_tuser;
  assign req.cell_value = in_tdata[VAL_W-1:0];
  assign req.x_pos      = in_tdata[VAL_W+COORD_W-1:VAL_W];
  assign req.y_pos      = in_tdata[VAL_W+2*COORD_W-1:VAL_W+COORD_W];
  assign req.margin_sq  = in_tdata[VAL_W+2*COORD_W+DIST_W-1:VAL_W+2*COORD_W];

  assign in_tready = core_idle;

  cgdm_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_tvalid && core_idle),
    .req       (req),
    .idle      (core_idle),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // Output register: take a new result when empty or being drained
  assign core_res_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_nxt        = out_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (core_res_valid && core_res_ready) begin
      out_nxt        = core_res;
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width    <= RST_GRID_WIDTH;
      cfg_r.grid_height   <= RST_GRID_HEIGHT;
      cfg_r.clip_sq       <= RST_CLIP_SQ;
      cfg_r.window_radius <= RST_WINDOW_RADIUS;
      out_tvalid_r        <= 1'b0;
    end else begin
      cfg_r        <= cfg_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_r.clear_of_margin, out_r.occupied, out_r.out_of_range,
                       out_r.dist_sq};
  assign out_tuser  = out_r.done_res;

endmodule

/* rtl/cgdm_mul.sv */
// Shared registered multiplier of the distance map sequencer.
// Stand-alone; no package needed.
module cgdm_mul #(
  parameter int W = 11
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* rtl/cgdm_core.sv */
// Sequencer, map memories and candidate arithmetic of the distance map.
// Depends on cgdm_pkg and cgdm_mul.
module cgdm_core #(
  parameter int MAX_WIDTH  = cgdm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = cgdm_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = cgdm_pkg::DEF_MAX_RADIUS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cgdm_pkg::cfg_t  cfg,
  input  logic            start,
  input  cgdm_pkg::req_t  req,
  output logic            idle,
  output logic            res_valid,
  input  logic            res_ready,
  output cgdm_pkg::res_t  res
);
  import cgdm_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int DW    = $clog2(MAX_RADIUS + 2);
  localparam int MW0   = (HW > COORD_W) ? HW : COORD_W;
  localparam int MW1   = (DW > MW0) ? DW : MW0;
  localparam int MW    = (RW > MW1) ? RW : MW1;
  localparam int PW    = 2 * MW;
  // Row distance that always lies outside any window
  localparam logic [DW-1:0] SAT = DW'(MAX_RADIUS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_IDX, S_ADDR, S_QRD, S_CSTART,
    S_F_RD, S_F_EX, S_B_RD, S_B_EX,
    S_CELL, S_W_RD, S_W_MUL, S_W_ACC, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  req_t            req_r, req_nxt;
  res_t            res_r, res_nxt;
  logic [CW-1:0]   x_r, x_nxt;
  logic [HW-1:0]   y_r, y_nxt;
  logic [HW-1:0]   yy_r, yy_nxt;
  logic [HW-1:0]   y1_r, y1_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]   col_base_r, col_base_nxt;
  logic [DW-1:0]   run_r, run_nxt;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [PW-1:0]   dy_sq_r, dy_sq_nxt;
  logic            skip_r, skip_nxt;

  // Effective extents
  logic [CW-1:0] ew;
  logic [HW-1:0] eh;
  logic [RW-1:0] er;

  // Memories: obstacle bit, nearest obstacle along the row, distance
  logic              occ_mem  [DEPTH];
  logic [DW-1:0]     near_mem [DEPTH];
  logic [DIST_W-1:0] dist_mem [DEPTH];
  logic              occ_q;
  logic [DW-1:0]     near_q;
  logic [DIST_W-1:0] dist_q;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              occ_we, occ_wd, near_we, dist_we;
  logic [DW-1:0]     near_wd;
  logic [DIST_W-1:0] dist_wd;

  logic [MW-1:0]     mul_a, mul_b;
  logic [PW-1:0]     mul_p;

  logic              in_grid;
  logic [AW-1:0]     idx;
  logic [HW-1:0]     y_lo, y_hi;
  logic [RW-1:0]     dy;
  logic [DW-1:0]     run_fwd, run_bwd;
  logic [PW:0]       sum_sq;
  logic [DIST_W-1:0] cand, best_c;

  assign ew = (32'(cfg.grid_width) < MAX_WIDTH) ? CW'(cfg.grid_width) : CW'(MAX_WIDTH);
  assign eh = (32'(cfg.grid_height) < MAX_HEIGHT) ? HW'(cfg.grid_height) : HW'(MAX_HEIGHT);
  assign er = (32'(cfg.window_radius) < MAX_RADIUS) ? RW'(cfg.window_radius)
                                                    : RW'(MAX_RADIUS);

  assign in_grid = (32'(req_r.x_pos) < 32'(ew)) && (32'(req_r.y_pos) < 32'(eh));
  assign idx     = AW'(mul_p) + AW'(req_r.y_pos);

  // Window rows for the current cell, clamped to the grid
  assign y_lo = (32'(y_r) > 32'(er)) ? HW'(32'(y_r) - 32'(er)) : '0;
  assign y_hi = ((32'(y_r) + 32'(er)) < (32'(eh) - 1)) ? HW'(32'(y_r) + 32'(er))
                                                        : HW'(32'(eh) - 1);
  assign dy   = (yy_r > y_r) ? RW'(yy_r - y_r) : RW'(y_r - yy_r);

  // Saturating distance counters for the row passes
  assign run_fwd = occ_q ? '0 : ((run_r == SAT) ? SAT : run_r + DW'(1));
  assign run_bwd = run_fwd;

  // Candidate in cell squared units with fraction, saturated to the field
  assign sum_sq = {1'b0, mul_p} + {1'b0, dy_sq_r};
  assign cand   = (sum_sq > (PW+1)'(CAND_LIMIT)) ? DIST_MAX
                                                 : {sum_sq[DIST_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
  assign best_c = (!skip_r && (cand < best_r)) ? cand : best_r;

  cgdm_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    res_nxt      = res_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    yy_nxt       = yy_r;
    y1_nxt       = y1_r;
    addr_nxt     = addr_r;
    col_base_nxt = col_base_r;
    run_nxt      = run_r;
    best_nxt     = best_r;
    dy_sq_nxt    = dy_sq_r;
    skip_nxt     = skip_r;
    mul_a        = '0;
    mul_b        = '0;
    rd_addr      = addr_r;
    wr_addr      = addr_r;
    occ_we       = 1'b0;
    occ_wd       = 1'b0;
    near_we      = 1'b0;
    near_wd      = run_fwd;
    dist_we      = 1'b0;
    dist_wd      = best_c;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = req;
          res_nxt = '0;
          case (op_t'(req.op))
            OP_LOAD, OP_QUERY: state_nxt = S_IDX;
            OP_COMPUTE:        state_nxt = S_CSTART;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_IDX: begin
        mul_a     = MW'(req_r.x_pos);
        mul_b     = MW'(eh);
        state_nxt = S_ADDR;
      end
      S_ADDR: begin
        rd_addr          = idx;
        wr_addr          = idx;
        res_nxt.done_res = 1'b1;
        if (op_t'(req_r.op) == OP_LOAD) begin
          occ_we    = in_grid;
          occ_wd    = !req_r.cell_value[VAL_W-1] && (req_r.cell_value != '0);
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_QRD;
        end
      end
      S_QRD: begin
        if (!in_grid) begin
          res_nxt.out_of_range = 1'b1;
        end else begin
          res_nxt.dist_sq         = dist_q;
          res_nxt.occupied        = occ_q;
          res_nxt.clear_of_margin = !occ_q && (dist_q >= req_r.margin_sq);
        end
        state_nxt = S_DONE;
      end
      S_CSTART: begin
        res_nxt.done_res = 1'b1;
        x_nxt            = '0;
        y_nxt            = '0;
        addr_nxt         = '0;
        run_nxt          = SAT;
        if ((ew == '0) || (eh == '0)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_EX;
      end
      S_F_EX: begin
        near_we = 1'b1;
        near_wd = run_fwd;
        run_nxt = run_fwd;
        if (x_r == ew - CW'(1)) begin
          run_nxt   = SAT;
          state_nxt = S_B_RD;
        end else begin
          x_nxt     = x_r + CW'(1);
          addr_nxt  = addr_r + AW'(eh);
          state_nxt = S_F_RD;
        end
      end
      S_B_RD: begin
        state_nxt = S_B_EX;
      end
      S_B_EX: begin
        near_we = 1'b1;
        near_wd = (near_q < run_bwd) ? near_q : run_bwd;
        run_nxt = run_bwd;
        if (x_r == '0) begin
          if (y_r == eh - HW'(1)) begin
            x_nxt        = '0;
            y_nxt        = '0;
            col_base_nxt = '0;
            state_nxt    = S_CELL;
          end else begin
            y_nxt     = y_r + HW'(1);
            addr_nxt  = AW'(y_r + HW'(1));
            run_nxt   = SAT;
            state_nxt = S_F_RD;
          end
        end else begin
          x_nxt     = x_r - CW'(1);
          addr_nxt  = addr_r - AW'(eh);
          state_nxt = S_B_RD;
        end
      end
      S_CELL: begin
        yy_nxt    = y_lo;
        y1_nxt    = y_hi;
        best_nxt  = cfg.clip_sq;
        state_nxt = S_W_RD;
      end
      S_W_RD: begin
        rd_addr   = col_base_r + AW'(yy_r);
        mul_a     = MW'(dy);
        mul_b     = MW'(dy);
        state_nxt = S_W_MUL;
      end
      S_W_MUL: begin
        mul_a     = MW'(near_q);
        mul_b     = MW'(near_q);
        dy_sq_nxt = mul_p;
        skip_nxt  = 32'(near_q) > 32'(er);
        state_nxt = S_W_ACC;
      end
      S_W_ACC: begin
        best_nxt = best_c;
        if (yy_r == y1_r) begin
          dist_we = 1'b1;
          wr_addr = col_base_r + AW'(y_r);
          dist_wd = best_c;
          if (y_r == eh - HW'(1)) begin
            y_nxt = '0;
            if (x_r == ew - CW'(1)) begin
              state_nxt = S_DONE;
            end else begin
              x_nxt        = x_r + CW'(1);
              col_base_nxt = col_base_r + AW'(eh);
              state_nxt    = S_CELL;
            end
          end else begin
            y_nxt     = y_r + HW'(1);
            state_nxt = S_CELL;
          end
        end else begin
          yy_nxt    = yy_r + HW'(1);
          state_nxt = S_W_RD;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    yy_r       <= yy_nxt;
    y1_r       <= y1_nxt;
    addr_r     <= addr_nxt;
    col_base_r <= col_base_nxt;
    run_r      <= run_nxt;
    best_r     <= best_nxt;
    dy_sq_r    <= dy_sq_nxt;
    skip_r     <= skip_nxt;
  end

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[wr_addr] <= occ_wd;
    end
    occ_q <= occ_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (near_we) begin
      near_mem[wr_addr] <= near_wd;
    end
    near_q <= near_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[wr_addr] <= dist_wd;
    end
    dist_q <= dist_mem[rd_addr];
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

endmodule

/* tb/tb_clipped_grid_distance_map.sv */
// Self-checking testbench for clipped_grid_distance_map: loads occupancy grids, builds the
// distance map and queries it, predicting every result from its own copy of the grids.
// Depends on cgdm_pkg and the clipped_grid_distance_map RTL; reads no files.
module tb_clipped_grid_distance_map;
  import cgdm_pkg::*;

  localparam int CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  // The op field has one code the block does not use; it must answer with all zeros
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam int NO_OBSTACLE = 65535;
  localparam logic [DIST_W-1:0] DIST_FULL = '1;
  localparam int MIXED_TARGET = 48;
  // Most of a correct run goes to the tall one-column compute with the widest
  // window; the limit allows many times the length of a correct run
  localparam int CYCLE_LIMIT = 2_000_000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  clipped_grid_distance_map dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Own copy of the block state: obstacle bits, stored distances and the registers
  logic              obstacle_bit [CELLS];
  logic [DIST_W-1:0] stored_dist  [CELLS];
  int                row_gap      [CELLS];
  logic [GRID_W-1:0] cols_reg   = RST_GRID_WIDTH;
  logic [GRID_W-1:0] rows_reg   = RST_GRID_HEIGHT;
  logic [DIST_W-1:0] clip_reg   = RST_CLIP_SQ;
  logic [RAD_W-1:0]  radius_reg = RST_WINDOW_RADIUS;

  res_t answers_due [$];
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  int   mixed_count    = 0;
  bit   steady_flow    = 1'b0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side stalls about 9 percent of the time, except during the steady stretch
  always @(negedge clk) begin
    out_tready <= steady_flow || ($urandom_range(99) >= 9);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int used_cols();
    return (cols_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(rows_reg);
  endfunction

  // Work out the answer to one accepted request and advance the copied state.
  // Cell (x, y) sits at x * rows + y, so the row count is also the stride.
  function automatic res_t predict_answer(input logic [OP_W-1:0] op,
                                          input logic signed [VAL_W-1:0] val,
                                          input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [DIST_W-1:0] margin);
    res_t ans;
    int   w, h, rad, idx, last, best, ylo, yhi, dx, dy, cand, gx, gy, yy;
    bit   seen, in_grid;
    ans     = '0;
    w       = used_cols();
    h       = used_rows();
    in_grid = (int'(x) < w) && (int'(y) < h);
    idx     = in_grid ? int'(x) * h + int'(y) : 0;
    case (op)
      OP_LOAD: begin
        // Only values above zero mark an obstacle; off-grid loads write nothing
        if (in_grid) obstacle_bit[idx] = (val > 0);
        ans.done_res = 1'b1;
      end
      OP_COMPUTE: begin
        rad = (radius_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(radius_reg);
        // Horizontal gap to the nearest obstacle in the same row, left sweep then right
        for (gy = 0; gy < h; gy++) begin
          seen = 1'b0;
          last = 0;
          for (gx = 0; gx < w; gx++) begin
            idx = gx * h + gy;
            if (obstacle_bit[idx]) begin
              last = gx;
              seen = 1'b1;
            end
            row_gap[idx] = seen ? gx - last : NO_OBSTACLE;
          end
          seen = 1'b0;
          for (gx = w - 1; gx >= 0; gx--) begin
            idx = gx * h + gy;
            if (obstacle_bit[idx]) begin
              last = gx;
              seen = 1'b1;
            end
            if (seen && (last - gx) < row_gap[idx]) row_gap[idx] = last - gx;
          end
        end
        // Scan the window rows; a gap wider than the radius lies outside the window
        for (gx = 0; gx < w; gx++) begin
          for (gy = 0; gy < h; gy++) begin
            best = int'(clip_reg);
            ylo  = (gy > rad) ? gy - rad : 0;
            yhi  = (gy + rad < h - 1) ? gy + rad : h - 1;
            for (yy = ylo; yy <= yhi; yy++) begin
              dx = row_gap[gx * h + yy];
              dy = (yy > gy) ? yy - gy : gy - yy;
              if (dx <= rad) begin
                cand = (dx * dx + dy * dy) << FRAC_W;
                // Saturate rather than wrap once the fraction no longer fits
                if (cand > int'(DIST_FULL)) cand = int'(DIST_FULL);
                if (cand < best) best = cand;
              end
            end
            stored_dist[gx * h + gy] = DIST_W'(best);
          end
        end
        ans.done_res = 1'b1;
      end
      OP_QUERY: begin
        if (!in_grid) begin
          ans.out_of_range = 1'b1;
        end else begin
          ans.dist_sq         = stored_dist[idx];
          ans.occupied        = obstacle_bit[idx];
          ans.clear_of_margin = !obstacle_bit[idx] && (stored_dist[idx] >= margin);
        end
        ans.done_res = 1'b1;
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input res_t want, input res_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: dist_sq %0d/%0d out_of_range %0b/%0b occupied %0b/%0b",
               $time, what, want.dist_sq, got.dist_sq, want.out_of_range,
               got.out_of_range, want.occupied, got.occupied);
    if (mismatch_count <= 10)
      $display("    clear_of_margin %0b/%0b done_res %0b/%0b (expected/actual)",
               want.clear_of_margin, got.clear_of_margin, want.done_res, got.done_res);
  endtask

  // Compare every accepted result with the oldest answer still due
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.dist_sq         = out_tdata[DIST_W-1:0];
      got.out_of_range    = out_tdata[DIST_W];
      got.occupied        = out_tdata[DIST_W+1];
      got.clear_of_margin = out_tdata[DIST_W+2];
      got.done_res        = out_tuser;
      if (answers_due.size() == 0) begin
        report_mismatch("result with nothing due", '0, got);
      end else begin
        want = answers_due.pop_front();
        if (got != want) report_mismatch("wrong result", want, got);
      end
    end
  end

  // Present one request, sometimes after a random gap, and hold it until accepted
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val,
                              input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [DIST_W-1:0] margin);
    @(negedge clk);
    if (!steady_flow && $urandom_range(99) < 9) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {4'b0, margin, y, x, val};
    do @(posedge clk); while (!in_tready);
    answers_due.push_back(predict_answer(op, val, x, y, margin));
  endtask

  // Drop the input and hold off until every answer has come back
  task automatic wait_for_answers();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_GRID_WIDTH:    cols_reg   = value[GRID_W-1:0];
      CFG_GRID_HEIGHT:   rows_reg   = value[GRID_W-1:0];
      CFG_CLIP_SQ:       clip_reg   = value[DIST_W-1:0];
      CFG_WINDOW_RADIUS: radius_reg = value[RAD_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setup(input int w, input int h, input logic [DIST_W-1:0] clip,
                             input int rad);
    write_register(CFG_GRID_WIDTH, CFG_DATA_W'(w));
    write_register(CFG_GRID_HEIGHT, CFG_DATA_W'(h));
    write_register(CFG_CLIP_SQ, clip);
    write_register(CFG_WINDOW_RADIUS, CFG_DATA_W'(rad));
  endtask

  // Load every cell of the grid in use; pct is the obstacle density in percent
  task automatic load_grid(input int pct);
    logic [VAL_W-1:0] val;
    for (int gx = 0; gx < used_cols(); gx++) begin
      for (int gy = 0; gy < used_rows(); gy++) begin
        if ($urandom_range(99) < pct) val = VAL_W'($urandom_range(127, 1));
        else val = VAL_W'(-$urandom_range(128));
        send_request(OP_LOAD, val, COORD_W'(gx), COORD_W'(gy), DIST_W'($urandom));
      end
    end
  endtask

  // Wait for idle, reconfigure, load the whole grid unless its cells already hold
  // loaded bits, and build the map, so that no compute reads an obstacle bit and
  // no query reads a distance never written
  task automatic build_map(input int w, input int h, input logic [DIST_W-1:0] clip,
                           input int rad, input int pct, input bit load_all);
    wait_for_answers();
    apply_setup(w, h, clip, rad);
    if (load_all) load_grid(pct);
    send_request(OP_COMPUTE, VAL_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                 DIST_W'($urandom));
  endtask

  // Mixed traffic on a built map: mostly in-grid queries with margins near the stored
  // distance, plus off-grid queries, loads, recomputes when with_compute is set and the spare op
  task automatic run_mixed(input int count, input bit with_compute);
    int                  w, h, pick, idx;
    logic [COORD_W-1:0]  x, y;
    logic [DIST_W-1:0]   margin;
    logic [VAL_W-1:0]    val;
    w = used_cols();
    h = used_rows();
    repeat (count) begin
      pick   = $urandom_range(99);
      x      = COORD_W'($urandom);
      y      = COORD_W'($urandom);
      margin = DIST_W'($urandom);
      val    = VAL_W'($urandom);
      if (pick < 60 && w > 0 && h > 0) begin
        x   = COORD_W'($urandom_range(w - 1));
        y   = COORD_W'($urandom_range(h - 1));
        idx = int'(x) * h + int'(y);
        case ($urandom_range(3))
          0: margin = stored_dist[idx];
          1: margin = stored_dist[idx] + 1'b1;
          2: margin = DIST_W'($urandom_range(int'(stored_dist[idx])));
          default: ;
        endcase
        send_request(OP_QUERY, val, x, y, margin);
      end else if (pick < 70) begin
        send_request(OP_QUERY, val, x, y, margin);
      end else if (pick < 88) begin
        if (w > 0 && h > 0 && $urandom_range(3) != 0) begin
          x = COORD_W'($urandom_range(w - 1));
          y = COORD_W'($urandom_range(h - 1));
        end
        send_request(OP_LOAD, val, x, y, margin);
      end else if (pick < 94 && with_compute) begin
        send_request(OP_COMPUTE, val, x, y, margin);
      end else begin
        send_request(OP_SPARE, val, x, y, margin);
      end
      mixed_count++;
    end
  endtask

  // Small 4 x 3 grid with obstacles in opposite corners, value extremes, off-grid
  // loads and queries, both margin extremes and the spare op
  task automatic test_directed();
    logic [VAL_W-1:0] pattern [12] = '{8'd127, 8'h80, 8'd0, 8'hFF, 8'd0, 8'h80,
                                       8'd0, 8'hF9, 8'd0, 8'hFF, 8'd0, 8'd1};
    apply_setup(4, 3, 20'd5000, 2);
    for (int gx = 0; gx < 4; gx++) begin
      for (int gy = 0; gy < 3; gy++) begin
        send_request(OP_LOAD, pattern[gx * 3 + gy], COORD_W'(gx), COORD_W'(gy), '0);
      end
    end
    send_request(OP_LOAD, 8'd127, 8'd4, 8'd0, '0);
    send_request(OP_LOAD, 8'd127, 8'd255, 8'd255, DIST_FULL);
    send_request(OP_COMPUTE, 8'd0, 8'd0, 8'd0, '0);
    send_request(OP_QUERY, 8'd0, 8'd0, 8'd0, '0);
    send_request(OP_QUERY, 8'd0, 8'd1, 8'd1, '0);
    send_request(OP_QUERY, 8'hFF, 8'd2, 8'd1, DIST_FULL);
    send_request(OP_QUERY, 8'd0, 8'd3, 8'd1, 20'd256);
    send_request(OP_QUERY, 8'd0, 8'd255, 8'd255, '0);
    send_request(OP_QUERY, 8'd0, 8'd0, 8'd3, '0);
    send_request(OP_SPARE, 8'hFF, 8'd255, 8'd255, DIST_FULL);
  endtask

  // On the directed grid: changing clip and radius must leave the stored map alone
  // until the next compute, which then picks up the new values
  task automatic test_map_kept_over_config();
    wait_for_answers();
    write_register(CFG_CLIP_SQ, 20'd300);
    write_register(CFG_WINDOW_RADIUS, 20'd0);
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) send_request(OP_COMPUTE, 8'd0, 8'd0, 8'd0, '0);
      for (int gx = 0; gx < 4; gx++) begin
        for (int gy = 0; gy < 3; gy++) begin
          send_request(OP_QUERY, 8'd0, COORD_W'(gx), COORD_W'(gy), 20'd300);
        end
      end
    end
  endtask

  // Register extremes: full width with clamped radius, oversize width, full height,
  // and empty grids in either direction
  task automatic test_extreme_sizes();
    // Obstacles at the two far ends of a full-width strip; cells 64 to 66 columns away
    // hit the saturated window candidate, which must never beat the full clip value
    build_map(256, 1, DIST_FULL, 127, 0, 1'b1);
    send_request(OP_LOAD, 8'd1, 8'd0, 8'd0, '0);
    send_request(OP_LOAD, 8'd127, 8'd255, 8'd0, '0);
    send_request(OP_COMPUTE, 8'd0, 8'd0, 8'd0, '0);
    for (int gx = 60; gx < 72; gx++) begin
      send_request(OP_QUERY, 8'd0, COORD_W'(gx), 8'd0, DIST_FULL);
      send_request(OP_QUERY, 8'd0, COORD_W'(255 - gx), 8'd0, 20'($urandom));
    end
    run_mixed(5, 1'b0);
    // A one-row or one-column grid of up to 256 cells sits on the cells the strip
    // loaded, so reuse its obstacle bits as they stand
    build_map(511, 1, 20'd1000, 0, 0, 1'b0);
    run_mixed(8, 1'b0);
    build_map(1, 256, DIST_FULL, 66, 0, 1'b0);
    run_mixed(8, 1'b0);
    build_map(0, 511, 20'd77, 67, 0, 1'b0);
    run_mixed(5, 1'b1);
    build_map(3, 0, 20'd77, 5, 0, 1'b0);
    run_mixed(5, 1'b1);
  endtask

  // Random small grids with random clip and radius; one phase runs without any
  // stalls, and every phase pauses once mid-way until all answers are in
  task automatic test_random_phases();
    int                phase;
    int                rad;
    logic [DIST_W-1:0] clip;
    phase       = 0;
    mixed_count = 0;
    while (mixed_count < MIXED_TARGET) begin
      steady_flow = (phase == 2);
      case ($urandom_range(4))
        0:       clip = '0;
        1:       clip = DIST_FULL;
        2:       clip = DIST_W'($urandom);
        default: clip = DIST_W'($urandom_range(60) << FRAC_W);
      endcase
      case ($urandom_range(5))
        0:       rad = 0;
        1:       rad = $urandom_range(127, 67);
        default: rad = $urandom_range(6, 1);
      endcase
      build_map($urandom_range(6, 1), $urandom_range(6, 1), clip, rad,
                $urandom_range(40, 5), 1'b1);
      run_mixed(8, 1'b1);
      wait_for_answers();
      run_mixed(8, 1'b1);
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_GRID_WIDTH;
    cfg_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_map_kept_over_config();
    test_extreme_sizes();
    test_random_phases();
    wait_for_answers();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
